FILE: rtl/vms_pkg.sv
package vms_pkg;

    // Default width of one signed stress component.
    localparam int STRESS_WIDTH_DEF = 24;

    // Width of the equivalent stress result, fixed by the output format.
    localparam int RESULT_WIDTH = 25;

    // Largest value the result can carry; larger roots saturate to it.
    localparam logic [RESULT_WIDTH-1:0] RESULT_MAX = {RESULT_WIDTH{1'b1}};

endpackage

FILE: rtl/vms_tensor_if.sv
interface vms_tensor_if #(
    parameter int STRESS_WIDTH = vms_pkg::STRESS_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [STRESS_WIDTH-1:0] s_xx;
    logic signed [STRESS_WIDTH-1:0] s_yy;
    logic signed [STRESS_WIDTH-1:0] s_zz;
    logic signed [STRESS_WIDTH-1:0] s_xy;
    logic signed [STRESS_WIDTH-1:0] s_xz;
    logic signed [STRESS_WIDTH-1:0] s_yz;

    modport source (
        output valid, s_xx, s_yy, s_zz, s_xy, s_xz, s_yz,
        input  ready
    );

    modport sink (
        input  valid, s_xx, s_yy, s_zz, s_xy, s_xz, s_yz,
        output ready
    );
endinterface

FILE: rtl/vms_result_if.sv
interface vms_result_if;
    logic                              valid;
    logic                              ready;
    logic [vms_pkg::RESULT_WIDTH-1:0]  equivalent_stress;

    modport source (
        output valid, equivalent_stress,
        input  ready
    );

    modport sink (
        input  valid, equivalent_stress,
        output ready
    );
endinterface

FILE: rtl/vms_root.sv
// Pipelined integer square root, one result bit per stage.
// Each stage brings down two radicand bits and does one trial subtract.
module vms_root #(
    parameter int ROOT_WIDTH = vms_pkg::STRESS_WIDTH_DEF + 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [2*ROOT_WIDTH-1:0]   i_radicand,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [ROOT_WIDTH-1:0]     o_root
);

    localparam int N    = ROOT_WIDTH;
    localparam int RADW = 2 * N;
    localparam int REMW = N + 1;
    localparam int TRW  = N + 3;

    // Stage inputs; index 0 is the block input, index k+1 is stage k's register.
    logic            w_valid [0:N];
    logic            w_ready [0:N];
    logic [RADW-1:0] w_rad   [0:N];
    logic [REMW-1:0] w_rem   [0:N];
    logic [N-1:0]    w_root  [0:N];

    // Stage registers.
    logic            r_valid [0:N-1];
    logic [RADW-1:0] r_rad   [0:N-1];
    logic [REMW-1:0] r_rem   [0:N-1];
    logic [N-1:0]    r_root  [0:N-1];

    assign w_valid[0] = i_valid;
    assign w_rad[0]   = i_radicand;
    assign w_rem[0]   = '0;
    assign w_root[0]  = '0;
    assign w_ready[N] = i_ready;
    assign o_ready    = w_ready[0];

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_stage
            logic [TRW-1:0]  w_shift;
            logic [TRW-1:0]  w_trial;
            logic [TRW-1:0]  w_diff;
            logic            w_fits;

            // A stage takes a new beat when it is empty or its contents move on.
            assign w_ready[k] = !r_valid[k] || w_ready[k+1];

            // Bring down two radicand bits and try to subtract 4*root+1.
            assign w_shift = {w_rem[k], w_rad[k][RADW-1 -: 2]};
            assign w_trial = {1'b0, w_root[k], 2'b01};
            assign w_diff  = w_shift - w_trial;
            assign w_fits  = w_shift >= w_trial;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[k] <= 1'b0;
                end else if (w_ready[k]) begin
                    r_valid[k] <= w_valid[k];
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_ready[k] && w_valid[k]) begin
                    r_rad[k]  <= {w_rad[k][RADW-3:0], 2'b00};
                    r_rem[k]  <= w_fits ? w_diff[REMW-1:0] : w_shift[REMW-1:0];
                    if (N > 1) begin
                        r_root[k] <= {w_root[k][N-2:0], w_fits};
                    end else begin
                        r_root[k] <= N'(w_fits);
                    end
                end
            end

            assign w_valid[k+1] = r_valid[k];
            assign w_rad[k+1]   = r_rad[k];
            assign w_rem[k+1]   = r_rem[k];
            assign w_root[k+1]  = r_root[k];
        end
    endgenerate

    assign o_valid = w_valid[N];
    assign o_root  = w_root[N];

endmodule

FILE: rtl/von_mises_stress_unit.sv
// Von Mises equivalent stress, fully pipelined.
// Four arithmetic stages, then one square root stage per root bit.
// Throughput: one tensor per cycle while the result is not stalled; every stage keeps its own valid bit.
// Reset clears the valid bits only; data registers are left as they are.
module von_mises_stress_unit #(
    parameter int STRESS_WIDTH = vms_pkg::STRESS_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    vms_tensor_if.sink    i_tensor,
    vms_result_if.source  o_result
);

    localparam int SW   = STRESS_WIDTH;
    localparam int DW   = SW + 1;
    localparam int PW   = 2 * SW;
    localparam int SUMW = 2 * SW + 2;
    localparam int RTW  = SW + 1;
    localparam int RW   = vms_pkg::RESULT_WIDTH;
    localparam int CW   = (RTW > RW) ? RTW : RW;

    // Magnitude of a sign-extended value; fits SW bits for every case used here.
    function automatic logic [SW-1:0] mag(input logic signed [DW-1:0] v);
        logic [DW-1:0] neg;
        neg = -v;
        return v[DW-1] ? neg[SW-1:0] : v[SW-1:0];
    endfunction

    logic            r_v1, r_v2, r_v3, r_v4;
    logic [SW-1:0]   r_mag [0:5];
    logic [PW-1:0]   r_sq  [0:5];
    logic [SUMW-1:0] r_nsum;
    logic [SUMW-1:0] r_ssum;
    logic [SUMW-1:0] r_q2;

    logic            w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_root_rdy;
    logic signed [DW-1:0] w_dab, w_dbc, w_dca, w_exy, w_exz, w_eyz;
    logic [SUMW-1:0] w_q2;
    logic [RTW-1:0]  w_root;
    logic [CW-1:0]   w_root_ext;
    logic            w_sat;

    // Backpressure: each stage moves when empty or when the next one moves.
    assign w_rdy4 = !r_v4 || w_root_rdy;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign i_tensor.ready = w_rdy1;

    // Normal stress differences and sign-extended shears.
    assign w_dab = {i_tensor.s_xx[SW-1], i_tensor.s_xx} - {i_tensor.s_yy[SW-1], i_tensor.s_yy};
    assign w_dbc = {i_tensor.s_yy[SW-1], i_tensor.s_yy} - {i_tensor.s_zz[SW-1], i_tensor.s_zz};
    assign w_dca = {i_tensor.s_zz[SW-1], i_tensor.s_zz} - {i_tensor.s_xx[SW-1], i_tensor.s_xx};
    assign w_exy = {i_tensor.s_xy[SW-1], i_tensor.s_xy};
    assign w_exz = {i_tensor.s_xz[SW-1], i_tensor.s_xz};
    assign w_eyz = {i_tensor.s_yz[SW-1], i_tensor.s_yz};

    // Q/2 = (sum of squared normal differences)/2 + 3 * (sum of shear squares).
    assign w_q2 = (r_nsum >> 1) + r_ssum + (r_ssum << 1);

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_tensor.valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
        end
    end

    // Stage 1: magnitudes of the three differences and the three shears.
    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_tensor.valid) begin
            r_mag[0] <= mag(w_dab);
            r_mag[1] <= mag(w_dbc);
            r_mag[2] <= mag(w_dca);
            r_mag[3] <= mag(w_exy);
            r_mag[4] <= mag(w_exz);
            r_mag[5] <= mag(w_eyz);
        end
    end

    // Stage 2: six squares in parallel.
    always_ff @(posedge i_clk) begin
        if (w_rdy2 && r_v1) begin
            for (int i = 0; i < 6; i++) begin
                r_sq[i] <= PW'(r_mag[i]) * PW'(r_mag[i]);
            end
        end
    end

    // Stage 3: normal and shear sums.
    always_ff @(posedge i_clk) begin
        if (w_rdy3 && r_v2) begin
            r_nsum <= SUMW'(r_sq[0]) + SUMW'(r_sq[1]) + SUMW'(r_sq[2]);
            r_ssum <= SUMW'(r_sq[3]) + SUMW'(r_sq[4]) + SUMW'(r_sq[5]);
        end
    end

    // Stage 4: the radicand Q/2.
    always_ff @(posedge i_clk) begin
        if (w_rdy4 && r_v3) begin
            r_q2 <= w_q2;
        end
    end

    vms_root #(
        .ROOT_WIDTH (RTW)
    ) u_root (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_v4),
        .o_ready    (w_root_rdy),
        .i_radicand (r_q2),
        .o_valid    (o_result.valid),
        .i_ready    (o_result.ready),
        .o_root     (w_root)
    );

    // Saturate roots that do not fit the result field.
    assign w_root_ext = CW'(w_root);
    assign w_sat      = w_root_ext > CW'(vms_pkg::RESULT_MAX);
    assign o_result.equivalent_stress = w_sat ? vms_pkg::RESULT_MAX : w_root_ext[RW-1:0];

    // No result is offered in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result.valid)
        else $error("result valid right after reset");

    // An empty first stage always takes a beat.
    a_front_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v1 |-> i_tensor.ready)
        else $error("input stalled with an empty first stage");

    // A stalled radicand holds until the root pipeline takes it.
    a_q2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && !w_root_rdy) |=> (r_v4 && $stable(r_q2)))
        else $error("radicand changed while stalled");

    // Saturation can only happen when the root is wider than the result.
    a_no_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && (RTW <= RW)) |-> !w_sat)
        else $error("unexpected saturation");

endmodule
